### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks used by sine_tone_generator; compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, held off during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### sv/stg_pkg.sv
// ----------------------------------------------------------------------------
// stg_pkg
// Shared types, register codes and the quarter-wave table builder.
// ----------------------------------------------------------------------------
package stg_pkg;

    localparam logic [63:0] PI_Q30      = 64'd3373259426;
    localparam logic [14:0] FULL_SCALE  = 15'd32767;
    localparam int          MAX_CHANNELS = 8;
    localparam logic [3:0]  CHAN_LIMIT  = (MAX_CHANNELS < 8) ? 4'(MAX_CHANNELS) : 4'd8;
    localparam int          CFG_ADDR_W  = 2;
    localparam int          CFG_DATA_W  = 32;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_PHASE_INC  = 2'd0,
        CFG_CHAN_COUNT = 2'd1,
        CFG_SAMPLE_FMT = 2'd2
    } t_cfg_index;

    typedef enum logic {
        FMT_FLOAT = 1'b0,
        FMT_INT16 = 1'b1
    } t_sample_fmt;

    // one looked-up point of the wave, ahead of encoding
    typedef struct packed {
        logic        neg;   // lower half of the turn
        logic        full;  // odd quadrant at address zero: full scale
        logic [15:0] tbl;   // table magnitude
    } t_sine_pt;

    // round(32768 * sin(pi/2 * idx / 2^abits)) by a Q30 Taylor series,
    // products truncated; evaluated at elaboration only
    function automatic logic [15:0] sine_entry(input int unsigned idx,
                                               input int unsigned abits);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        prod;
        logic signed [63:0] sum;
        logic [63:0]        r;
        x    = (PI_Q30 * 64'(idx)) >> (abits + 1);
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        for (int k = 1; k <= 8; k++) begin
            prod = (term * x2) >> 30;
            case (k)
                1:       term = prod / 64'd6;
                2:       term = prod / 64'd20;
                3:       term = prod / 64'd42;
                4:       term = prod / 64'd72;
                5:       term = prod / 64'd110;
                6:       term = prod / 64'd156;
                7:       term = prod / 64'd210;
                default: term = prod / 64'd272;
            endcase
            if ((k & 1) != 0) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        if (sum < 0) begin
            sum = 64'sd0;
        end
        r = ((unsigned'(sum) * 64'd32768) + (64'd1 << 29)) >> 30;
        if (r > 64'(FULL_SCALE)) begin
            r = 64'(FULL_SCALE);
        end
        return r[15:0];
    endfunction

endpackage

### sv/stg_frame_if.sv
// ----------------------------------------------------------------------------
// stg_frame_if
// Frame request channel: valid/ready handshake with a one-bit tick.
// ----------------------------------------------------------------------------
interface stg_frame_if;
    logic valid;
    logic ready;
    logic frame_tick;

    modport source (output valid, output frame_tick, input ready);
    modport sink   (input valid, input frame_tick, output ready);
endinterface

### sv/stg_sample_if.sv
// ----------------------------------------------------------------------------
// stg_sample_if
// Sample channel: one word per channel copy, last copy of a frame marked.
// ----------------------------------------------------------------------------
interface stg_sample_if;
    logic        valid;
    logic        ready;
    logic [31:0] sample_word;
    logic [2:0]  channel_index;
    logic        last_in_frame;

    modport source (output valid, output sample_word, output channel_index,
                    output last_in_frame, input ready);
    modport sink   (input valid, input sample_word, input channel_index,
                    input last_in_frame, output ready);
endinterface

### sv/sine_tone_generator.sv
// ----------------------------------------------------------------------------
// sine_tone_generator
// Phase-accumulator sine oscillator; one frame request with frame_tick set yields one sample
// word repeated once per channel.
// ----------------------------------------------------------------------------
//   port       dir   word                               done when
//   i_frame    in    frame_tick                         valid && ready
//   o_sample   out   sample_word, channel_index, last   valid && ready
//   i_cfg_*    in    index, 32-bit data                 i_cfg_we high
//
// A frame yields n copies on the output, n = channel count clamped to 1..8;
// the output register sends one channel copy per cycle while ready is high.
// The word is read from the table into a register, then encoded into the output.
// A request is taken while the previous frame's copies are still going out.
// Reset is synchronous; the table is constant, so there is no fill pass.
// ----------------------------------------------------------------------------
module sine_tone_generator #(
    parameter int PHASE_BITS      = 32,
    parameter int TABLE_ADDR_BITS = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    stg_frame_if.sink                       i_frame,
    stg_sample_if.source                    o_sample,
    input  logic                            i_cfg_we,
    input  logic [stg_pkg::CFG_ADDR_W-1:0]  i_cfg_index,
    input  logic [stg_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import stg_pkg::*;

    localparam int TOP_BITS = TABLE_ADDR_BITS + 2;

    // configuration
    logic [31:0]        r_phase_inc;
    logic [3:0]         r_chan_count;
    t_sample_fmt        r_fmt;

    logic [PHASE_BITS-1:0] r_phase;

    // table read stage
    logic               r_s1_valid;
    logic               r_s1_neg;
    logic               r_s1_full;
    logic [15:0]        w_rom_data;

    // output register
    logic               r_out_valid;
    logic [31:0]        r_word;
    logic [2:0]         r_idx;
    logic               r_last;

    logic [TOP_BITS-1:0]        w_top;
    logic [1:0]                 w_quad;
    logic [TABLE_ADDR_BITS-1:0] w_a;
    logic [TABLE_ADDR_BITS-1:0] w_rd_addr;
    logic                       w_in_acc;
    logic                       w_go;
    logic                       w_out_acc;
    logic                       w_s1_adv;
    logic [2:0]                 w_n_m1;
    t_sine_pt                   w_pt;
    logic [31:0]                w_enc_word;

    assign w_top     = r_phase[PHASE_BITS-1 -: TOP_BITS];
    assign w_quad    = w_top[TOP_BITS-1 -: 2];
    assign w_a       = w_top[TABLE_ADDR_BITS-1:0];
    // odd quadrants run the table backward
    assign w_rd_addr = w_quad[0] ? ({TABLE_ADDR_BITS{1'b0}} - w_a) : w_a;

    assign w_in_acc  = i_frame.valid && i_frame.ready;
    assign w_go      = w_in_acc && i_frame.frame_tick;
    assign w_out_acc = r_out_valid && o_sample.ready;
    assign w_s1_adv  = r_s1_valid && (!r_out_valid || (o_sample.ready && r_last));

    assign i_frame.ready = !r_s1_valid || w_s1_adv;

    always_comb begin
        if (r_chan_count == 4'd0) begin
            w_n_m1 = 3'd0;
        end else if (r_chan_count > CHAN_LIMIT) begin
            w_n_m1 = 3'(CHAN_LIMIT - 4'd1);
        end else begin
            w_n_m1 = 3'(r_chan_count - 4'd1);
        end
    end

    stg_sine_rom #(
        .ADDR_BITS (TABLE_ADDR_BITS)
    ) u_rom (
        .i_clk  (i_clk),
        .i_en   (w_go),
        .i_addr (w_rd_addr),
        .o_data (w_rom_data)
    );

    assign w_pt.neg  = r_s1_neg;
    assign w_pt.full = r_s1_full;
    assign w_pt.tbl  = w_rom_data;

    stg_encode u_encode (
        .i_pt   (w_pt),
        .i_fmt  (r_fmt),
        .o_word (w_enc_word)
    );

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_inc  <= 32'd0;
            r_chan_count <= 4'd2;
            r_fmt        <= FMT_FLOAT;
            r_phase      <= '0;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_idx        <= 3'd0;
            r_last       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PHASE_INC:  r_phase_inc  <= i_cfg_wdata[31:0];
                    CFG_CHAN_COUNT: r_chan_count <= i_cfg_wdata[3:0];
                    CFG_SAMPLE_FMT: r_fmt        <= t_sample_fmt'(i_cfg_wdata[0]);
                    default: ;
                endcase
            end

            // advance the phase once the current point is being read
            if (w_go) begin
                r_phase <= r_phase + PHASE_BITS'(r_phase_inc);
            end

            if (w_go) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (w_s1_adv) begin
                r_out_valid <= 1'b1;
                r_idx       <= 3'd0;
                r_last      <= (w_n_m1 == 3'd0);
            end else if (w_out_acc) begin
                if (r_last) begin
                    r_out_valid <= 1'b0;
                end else begin
                    r_idx  <= r_idx + 3'd1;
                    r_last <= ((r_idx + 3'd1) == w_n_m1);
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_s1_neg  <= w_quad[1];
            r_s1_full <= w_quad[0] && (w_a == '0);
        end
        if (w_s1_adv) begin
            r_word <= w_enc_word;
        end
    end

    assign o_sample.valid         = r_out_valid;
    assign o_sample.sample_word   = r_word;
    assign o_sample.channel_index = r_idx;
    assign o_sample.last_in_frame = r_last;

`include "assert_macros.svh"

    `ASSERT_NEXT(a_idx_step, i_clk, i_rst_n, w_out_acc && !r_last && !w_s1_adv, r_idx == ($past(r_idx) + 3'd1))
    `ASSERT_IMPLIES(a_last_at_count, i_clk, i_rst_n, r_out_valid && r_last, r_idx == w_n_m1)
    `ASSERT_NEXT(a_s1_held, i_clk, i_rst_n, r_s1_valid && !w_s1_adv, r_s1_valid)
    `ASSERT_NEXT(a_phase_hold, i_clk, i_rst_n, !w_go, r_phase == $past(r_phase))

endmodule

### sv/stg_sine_rom.sv
// ----------------------------------------------------------------------------
// stg_sine_rom
// Quarter-wave sine table, contents fixed at elaboration, registered read.
// ----------------------------------------------------------------------------
module stg_sine_rom #(
    parameter int ADDR_BITS = 10
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [ADDR_BITS-1:0] i_addr,
    output logic [15:0]          o_data
);
    import stg_pkg::*;

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [15:0] w_table [DEPTH];
    logic [15:0] r_data;

    for (genvar g = 0; g < DEPTH; g++) begin : g_entry
        assign w_table[g] = sine_entry(g, ADDR_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= w_table[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

### sv/stg_encode.sv
// ----------------------------------------------------------------------------
// stg_encode
// Signed sine point scaled by one quarter, as float32 bits or int16.
// ----------------------------------------------------------------------------
module stg_encode (
    input  stg_pkg::t_sine_pt    i_pt,
    input  stg_pkg::t_sample_fmt i_fmt,
    output logic [31:0]          o_word
);
    import stg_pkg::*;

    logic [14:0] w_mag;
    logic [3:0]  w_msb;
    logic [23:0] w_norm;
    logic [31:0] w_float;
    logic [29:0] w_prod;
    logic [12:0] w_q;
    logic [15:0] w_int;

    assign w_mag = i_pt.full ? FULL_SCALE : i_pt.tbl[14:0];

    // leading one of the magnitude
    always_comb begin
        w_msb = 4'd0;
        for (int i = 0; i < 15; i++) begin
            if (w_mag[i]) begin
                w_msb = 4'(i);
            end
        end
    end

    // value is mag / 2^17: exponent msb + 110, drop the hidden bit
    assign w_norm  = 24'(w_mag) << (5'd23 - 5'(w_msb));
    assign w_float = (w_mag == 15'd0) ? 32'd0
                   : {i_pt.neg, 8'(w_msb) + 8'd110, w_norm[22:0]};

    // mag * 32767 / 2^17, truncated toward zero
    assign w_prod = {w_mag, 15'd0} - 30'(w_mag);
    assign w_q    = w_prod[29:17];
    assign w_int  = i_pt.neg ? (16'd0 - 16'(w_q)) : 16'(w_q);

    assign o_word = (i_fmt == FMT_INT16) ? {16'd0, w_int} : w_float;

endmodule

### bench/stg_sample_checker.sv
// ----------------------------------------------------------------------------
// stg_sample_checker
// Watches the frame and sample channels and the register port of the sine
// tone generator, predicts every sample word from its own phase accumulator
// and quarter-wave table, and compares each delivered copy in order.
// ----------------------------------------------------------------------------
module stg_sample_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    stg_frame_if                            i_frame_mon,
    stg_sample_if                           i_sample_mon,
    input  logic                            i_cfg_we,
    input  logic [stg_pkg::CFG_ADDR_W-1:0]  i_cfg_index,
    input  logic [stg_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    output int                              o_fail_count,
    output int                              o_pending
);
    import stg_pkg::*;

    localparam int              QTR_BITS   = 10;
    localparam int              QTR_SIZE   = 1 << QTR_BITS;
    localparam longint unsigned PI_IN_Q30  = 64'd3373259426;
    localparam int              PEAK       = 32767;
    localparam int              REPORT_MAX = 10;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  chan;
        logic        last;
    } t_sample_copy;

    logic [15:0]  quarter_wave [QTR_SIZE];
    t_sample_copy copies_due [$];
    logic [31:0]  phase;
    logic [31:0]  phase_step;
    logic [3:0]   chan_setting;
    t_sample_fmt  fmt;

    // sin(pi/2 * idx / QTR_SIZE) in Q1.15 by a nine-term Q30 series
    function automatic logic [15:0] quarter_entry(int unsigned idx);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned r;
        longint          sum;
        x    = (PI_IN_Q30 * longint'(idx)) >> (QTR_BITS + 1);
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int k = 1; k <= 8; k++) begin
            term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        r = (longint'(sum) * 32768 + (64'd1 << 29)) >> 30;
        if (r > PEAK) begin
            r = PEAK;
        end
        return r[15:0];
    endfunction

    function automatic int sine_at(logic [31:0] ph);
        logic [1:0]          quad;
        logic [QTR_BITS-1:0] addr;
        int                  mag;
        quad = ph[31:30];
        addr = ph[29:20];
        if (quad[0]) begin
            // mirror the table on odd quadrants; address zero is the crest
            mag = (addr == 0) ? PEAK : int'(quarter_wave[QTR_BITS'(QTR_SIZE - addr)]);
        end else begin
            mag = int'(quarter_wave[addr]);
        end
        return quad[1] ? -mag : mag;
    endfunction

    // s / 131072 as float32; zero stays +0.0
    function automatic logic [31:0] float_bits(int s);
        logic [31:0] m;
        logic [31:0] bits;
        int          msb;
        m   = (s < 0) ? -s : s;
        msb = 0;
        if (m == 0) begin
            return 32'h0;
        end
        for (int b = 0; b < 16; b++) begin
            if (m[b]) begin
                msb = b;
            end
        end
        bits = (32'(msb + 110) << 23) | ((m << (23 - msb)) & 32'h007F_FFFF);
        if (s < 0) begin
            bits[31] = 1'b1;
        end
        return bits;
    endfunction

    // trunc(s * 32767 / 131072) in the low half, upper half zero
    function automatic logic [31:0] int16_bits(int s);
        logic [31:0] m;
        logic [31:0] q;
        m = (s < 0) ? -s : s;
        q = (m * 32'd32767) >> 17;
        if (s < 0) begin
            q = (32'd0 - q) & 32'h0000_FFFF;
        end
        return q;
    endfunction

    task automatic queue_frame();
        int           s;
        int unsigned  copies;
        logic [31:0]  word;
        t_sample_copy c;
        s    = sine_at(phase);
        word = (fmt == FMT_INT16) ? int16_bits(s) : float_bits(s);
        copies = chan_setting;
        if (copies == 0) begin
            copies = 1;
        end
        if (copies > CHAN_LIMIT) begin
            copies = CHAN_LIMIT;
        end
        for (int unsigned j = 0; j < copies; j++) begin
            c.word = word;
            c.chan = 3'(j);
            c.last = (j + 1 == copies);
            copies_due.push_back(c);
        end
        phase = phase + phase_step;
    endtask

    initial begin
        for (int i = 0; i < QTR_SIZE; i++) begin
            quarter_wave[i] = quarter_entry(i);
        end
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_sample_copy got;
        t_sample_copy want;
        if (!i_rst_n) begin
            phase        = '0;
            phase_step   = '0;
            chan_setting = 4'd2;
            fmt          = FMT_FLOAT;
            copies_due.delete();
        end else begin
            if (i_sample_mon.valid && i_sample_mon.ready) begin
                got.word = i_sample_mon.sample_word;
                got.chan = i_sample_mon.channel_index;
                got.last = i_sample_mon.last_in_frame;
                if (copies_due.size() == 0) begin
                    if (o_fail_count < REPORT_MAX) begin
                        $display("%0t: unexpected word: word %h chan %0d last %0b",
                                 $time, got.word, got.chan, got.last);
                    end
                    o_fail_count++;
                end else begin
                    want = copies_due.pop_front();
                    if (got.word !== want.word || got.chan !== want.chan ||
                        got.last !== want.last) begin
                        if (o_fail_count < REPORT_MAX) begin
                            $display("%0t: mismatch: word %h/%h chan %0d/%0d last %0b/%0b",
                                     $time, want.word, got.word, want.chan, got.chan,
                                     want.last, got.last);
                        end
                        o_fail_count++;
                    end
                end
            end
            if (i_frame_mon.valid && i_frame_mon.ready && i_frame_mon.frame_tick) begin
                queue_frame();
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PHASE_INC:  phase_step   = i_cfg_wdata;
                    CFG_CHAN_COUNT: chan_setting = i_cfg_wdata[3:0];
                    CFG_SAMPLE_FMT: fmt          = t_sample_fmt'(i_cfg_wdata[0]);
                    default: ;
                endcase
            end
        end
        o_pending = copies_due.size();
    end

endmodule

### bench/tb_sine_tone_generator.sv
// ----------------------------------------------------------------------------
// tb_sine_tone_generator
// Drives frame requests and register writes into the sine tone generator,
// stalls the sample channel at random, and reports the checker's verdict.
// Directed frames hit the quadrant edges and register extremes first, then
// random phases with random settings follow.
// ----------------------------------------------------------------------------
module tb_sine_tone_generator;
    import stg_pkg::*;

    localparam int                    FRAME_ITEMS   = 220;
    localparam int                    SETTLE_CYCLES = 6;
    localparam int                    LONG_HOLD     = 300;
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED    = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    int                    fail_count;
    int                    pending;
    bit                    rx_hold_req;
    bit                    rx_steady;
    int                    frames_sent;

    stg_frame_if  frame_ch ();
    stg_sample_if sample_ch ();

    sine_tone_generator u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_frame     (frame_ch),
        .o_sample    (sample_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    stg_sample_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_frame_mon  (frame_ch),
        .i_sample_mon (sample_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int idle_len(bit steady);
        int r;
        if (steady) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] pick_step();
        case ($urandom_range(0, 4))
            0:       return $urandom_range(0, 32'h0010_0000);
            1:       return 32'hFFFF_FFFF - $urandom_range(0, 32'h0010_0000);
            2:       return 32'($urandom_range(1, 15)) << 28;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [3:0] pick_channels();
        if ($urandom_range(0, 3) != 0) begin
            return 4'($urandom_range(1, 8));
        end
        return 4'($urandom_range(0, 15));
    endfunction

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // valid stays high between back-to-back words
    task automatic send_frame(bit tick, bit steady);
        int gap;
        gap = idle_len(steady);
        if (gap > 0) begin
            @(negedge clk);
            frame_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        frame_ch.valid      <= 1'b1;
        frame_ch.frame_tick <= tick;
        do begin
            @(posedge clk);
        end while (!frame_ch.ready);
    endtask

    // drop valid, wait for every copy, then let a request with no result clear
    task automatic drain_frames();
        @(negedge clk);
        frame_ch.valid <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_frames(int count, bit steady);
        int done;
        bit tick;
        done = 0;
        while (done < count) begin
            tick = ($urandom_range(0, 15) != 0);
            send_frame(tick, steady);
            if (tick) begin
                done++;
            end
        end
        frames_sent += count;
    endtask

    // sample channel: bursts of ready, random gaps, one long hold on request
    initial begin
        int run_left;
        int gap_left;
        int hold_left;
        run_left  = 0;
        gap_left  = 0;
        hold_left = 0;
        sample_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                sample_ch.ready <= 1'b0;
                hold_left--;
            end else if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left   = LONG_HOLD - 1;
                sample_ch.ready <= 1'b0;
            end else if (run_left > 0) begin
                sample_ch.ready <= 1'b1;
                run_left--;
            end else if (gap_left > 0) begin
                sample_ch.ready <= 1'b0;
                gap_left--;
            end else begin
                run_left = $urandom_range(0, 23);
                gap_left = idle_len(rx_steady);
                sample_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        int phase_no;
        frame_ch.valid      = 1'b0;
        frame_ch.frame_tick = 1'b1;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_wdata           = '0;
        rx_hold_req         = 1'b0;
        rx_steady           = 1'b0;
        frames_sent         = 0;
        rst_n               = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: phase held at zero, two float copies of +0.0
        send_frame(1'b1, 1'b1);
        send_frame(1'b0, 1'b1);
        send_frame(1'b1, 1'b1);
        drain_frames();

        // quarter-turn steps: zero, crest, zero again (sent as +0.0), trough
        write_reg(CFG_PHASE_INC, 32'h4000_0000);
        write_reg(CFG_CHAN_COUNT, 32'd1);
        repeat (5) send_frame(1'b1, 1'b1);
        drain_frames();

        write_reg(CFG_SAMPLE_FMT, FMT_INT16);
        write_reg(CFG_CHAN_COUNT, 32'd8);
        repeat (4) send_frame(1'b1, 1'b0);
        drain_frames();

        // largest step runs backward; zero channels acts as one
        write_reg(CFG_PHASE_INC, 32'hFFFF_FFFF);
        write_reg(CFG_CHAN_COUNT, 32'd0);
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        repeat (3) send_frame(1'b1, 1'b0);
        drain_frames();

        write_reg(CFG_SAMPLE_FMT, FMT_FLOAT);
        write_reg(CFG_CHAN_COUNT, 32'd15);
        write_reg(CFG_PHASE_INC, 32'h000F_FFFF);
        repeat (3) send_frame(1'b1, 1'b0);
        drain_frames();

        write_reg(CFG_SAMPLE_FMT, FMT_INT16);
        write_reg(CFG_CHAN_COUNT, 32'd9);
        write_reg(CFG_PHASE_INC, 32'h8000_0001);
        repeat (3) send_frame(1'b1, 1'b0);
        send_frame(1'b0, 1'b0);
        drain_frames();

        phase_no = 0;
        while (frames_sent < FRAME_ITEMS) begin
            if ($urandom_range(0, 9) < 7) begin
                write_reg(CFG_PHASE_INC, pick_step());
            end
            if ($urandom_range(0, 9) < 7) begin
                write_reg(CFG_CHAN_COUNT, ($urandom() & 32'hFFFF_FFF0) | pick_channels());
            end
            if ($urandom_range(0, 9) < 6) begin
                write_reg(CFG_SAMPLE_FMT, ($urandom() & 32'hFFFF_FFFE) | $urandom_range(0, 1));
            end
            if ($urandom_range(0, 9) == 0) begin
                write_reg(CFG_UNUSED, $urandom());
            end
            rx_steady = ($urandom_range(0, 3) == 0);
            // hold the sample side so the block backs up into the request side
            if (phase_no == 2) begin
                rx_hold_req = 1'b1;
            end
            run_frames($urandom_range(8, 30), $urandom_range(0, 3) == 0);
            drain_frames();
            phase_no++;
        end

        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
